[hdl/lrupr_pkg.sv]
// shared constants and control types of the lru page replacement block
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    localparam int NUM_FRAMES_W  = 5;
    localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST = 5'd16;

    localparam int COUNT_W       = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int FRAME_INDEX_W = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // register index taken from the word address bit
    localparam logic REG_NUM_FRAMES = 1'b0;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // status travelling along the cell chain with the search token
    typedef struct packed {
        logic tok;
        logic hit_found;
        logic empty_found;
    } chain_flags_t;

    // update broadcast to every cell when a transaction completes
    typedef struct packed {
        logic apply;
        logic clear;
        logic fill;
    } upd_ctrl_t;

endpackage

[hdl/lrupr_cell.sv]
// one frame cell: page, valid and recency rank, plus its stage of the search chain
`timescale 1ns / 1ps

module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int CELL_IDX  = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_use,
    input  logic [PAGE_BITS-1:0] lookup_page,
    input  chain_flags_t         flags_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [IDX_W-1:0]     hit_rank_in,
    input  logic [IDX_W-1:0]     empty_idx_in,
    input  logic [IDX_W-1:0]     empty_rank_in,
    input  logic [IDX_W-1:0]     lru_idx_in,
    input  logic [IDX_W-1:0]     lru_rank_in,
    input  logic [PAGE_BITS-1:0] lru_page_in,
    input  upd_ctrl_t            upd,
    input  logic [IDX_W-1:0]     upd_idx,
    input  logic [IDX_W-1:0]     upd_rank_old,
    input  logic [PAGE_BITS-1:0] upd_page,
    output chain_flags_t         flags_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [IDX_W-1:0]     hit_rank_out,
    output logic [IDX_W-1:0]     empty_idx_out,
    output logic [IDX_W-1:0]     empty_rank_out,
    output logic [IDX_W-1:0]     lru_idx_out,
    output logic [IDX_W-1:0]     lru_rank_out,
    output logic [PAGE_BITS-1:0] lru_page_out
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(FRAMES - 1);
    localparam bit               FIRST    = (CELL_IDX == 0);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [IDX_W-1:0]     rank_reg;

    chain_flags_t         flags_reg, flags_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]     hit_rank_reg, hit_rank_next;
    logic [IDX_W-1:0]     empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]     empty_rank_reg, empty_rank_next;
    logic [IDX_W-1:0]     lru_idx_reg, lru_idx_next;
    logic [IDX_W-1:0]     lru_rank_reg, lru_rank_next;
    logic [PAGE_BITS-1:0] lru_page_reg, lru_page_next;

    logic take_hit, take_empty, take_lru;

    always_comb begin
        take_hit   = in_use && !flags_in.hit_found && valid_reg && (page_reg == lookup_page);
        take_empty = in_use && !flags_in.empty_found && !valid_reg;
        // first cell always seeds the oldest-frame search
        take_lru   = in_use && (FIRST || (rank_reg < lru_rank_in));

        flags_next.tok         = flags_in.tok;
        flags_next.hit_found   = flags_in.hit_found | take_hit;
        flags_next.empty_found = flags_in.empty_found | take_empty;
        hit_idx_next    = take_hit   ? MY_IDX   : hit_idx_in;
        hit_rank_next   = take_hit   ? rank_reg : hit_rank_in;
        empty_idx_next  = take_empty ? MY_IDX   : empty_idx_in;
        empty_rank_next = take_empty ? rank_reg : empty_rank_in;
        lru_idx_next    = take_lru   ? MY_IDX   : lru_idx_in;
        lru_rank_next   = take_lru   ? rank_reg : lru_rank_in;
        lru_page_next   = take_lru   ? page_reg : lru_page_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        empty_idx_reg  <= empty_idx_next;
        empty_rank_reg <= empty_rank_next;
        lru_idx_reg    <= lru_idx_next;
        lru_rank_reg   <= lru_rank_next;
        lru_page_reg   <= lru_page_next;
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn || upd.clear) begin
            valid_reg <= 1'b0;
            rank_reg  <= MY_IDX;
        end else if (upd.apply) begin
            if (upd_idx == MY_IDX) begin
                rank_reg <= TOP_RANK;
                if (upd.fill) begin
                    valid_reg <= 1'b1;
                end
            end else if (rank_reg > upd_rank_old) begin
                rank_reg <= rank_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.apply && upd.fill && (upd_idx == MY_IDX)) begin
            page_reg <= upd_page;
        end
    end

    assign flags_out      = flags_reg;
    assign hit_idx_out    = hit_idx_reg;
    assign hit_rank_out   = hit_rank_reg;
    assign empty_idx_out  = empty_idx_reg;
    assign empty_rank_out = empty_rank_reg;
    assign lru_idx_out    = lru_idx_reg;
    assign lru_rank_out   = lru_rank_reg;
    assign lru_page_out   = lru_page_reg;

endmodule

[hdl/lru_page_replacement_top.sv]
// top level of the lru page replacement block: control, counters, output stage, register port
`timescale 1ns / 1ps
//
//  channel     | direction | handshake                     | content
//  ------------+-----------+-------------------------------+------------------------------------
//  s_axis      | in        | s_axis_tvalid / s_axis_tready | page reference or clear command
//  m_axis      | out       | m_axis_tvalid / m_axis_tready | hit, frame, victim, running totals
//  apb         | in        | psel / penable / pready       | num_frames register
//
//  a page reference launches the search token from launch_reg, walks it through the cell registers,
//  captures the chain end in the result registers and then commits; no new transaction is taken before
//  that commit; a clear command goes straight to the commit and skips the chain walk
//  the finished result sits in an output register, so a new transaction is taken while it waits;
//  a stalled m_axis only holds the block once a second result is ready to commit
//  reset is synchronous: all frames empty, ranks in frame order, totals zero, num_frames 16

module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    localparam int IN_DATA_W  = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((FRAME_INDEX_W + PAGE_BITS + 2 * COUNT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // page
    input  logic [0:0]            s_axis_tuser,   // command

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // frame_index, victim_page, access_total,
                                                  // miss_total
    output logic [1:0]            m_axis_tuser,   // hit, victim_valid

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // control states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [NUM_FRAMES_W-1:0] num_frames_reg;

    // held transaction
    logic                 cmd_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 launch_reg;

    // captured search result
    logic                 res_hit_reg, res_empty_reg;
    logic [IDX_W-1:0]     res_hit_idx_reg, res_hit_rank_reg;
    logic [IDX_W-1:0]     res_empty_idx_reg, res_empty_rank_reg;
    logic [IDX_W-1:0]     res_lru_idx_reg, res_lru_rank_reg;
    logic [PAGE_BITS-1:0] res_lru_page_reg;

    logic [COUNT_W-1:0] access_reg, access_next;
    logic [COUNT_W-1:0] miss_reg, miss_next;

    // output stage
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0]            m_user_reg, m_user_next;

    logic s_accept, commit, is_clear, victim, cfg_write;

    upd_ctrl_t            upd;
    logic [IDX_W-1:0]     upd_idx, upd_rank_old;
    logic [PAGE_BITS-1:0] victim_page;
    logic [IDX_W+FRAME_INDEX_W-1:0] idx_ext;

    // chain taps: entry g feeds cell g, entry FRAMES is the chain end
    chain_flags_t         ch_flags    [FRAMES+1];
    logic [IDX_W-1:0]     ch_hit_idx  [FRAMES+1];
    logic [IDX_W-1:0]     ch_hit_rank [FRAMES+1];
    logic [IDX_W-1:0]     ch_emp_idx  [FRAMES+1];
    logic [IDX_W-1:0]     ch_emp_rank [FRAMES+1];
    logic [IDX_W-1:0]     ch_lru_idx  [FRAMES+1];
    logic [IDX_W-1:0]     ch_lru_rank [FRAMES+1];
    logic [PAGE_BITS-1:0] ch_lru_page [FRAMES+1];
    logic [FRAMES-1:0]    tok_vec;

    // chain head: token plus empty status
    assign ch_flags[0]    = '{tok: launch_reg, hit_found: 1'b0, empty_found: 1'b0};
    assign ch_hit_idx[0]  = '0;
    assign ch_hit_rank[0] = '0;
    assign ch_emp_idx[0]  = '0;
    assign ch_emp_rank[0] = '0;
    assign ch_lru_idx[0]  = '0;
    assign ch_lru_rank[0] = '0;
    assign ch_lru_page[0] = '0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic in_use;
        // a count of zero still uses the first frame, a count of FRAMES or more uses them all
        assign in_use = (g == 0) || (32'(g) < 32'(num_frames_reg));
        assign tok_vec[g] = ch_flags[g+1].tok;

        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (g)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .in_use         (in_use),
            .lookup_page    (page_reg),
            .flags_in       (ch_flags[g]),
            .hit_idx_in     (ch_hit_idx[g]),
            .hit_rank_in    (ch_hit_rank[g]),
            .empty_idx_in   (ch_emp_idx[g]),
            .empty_rank_in  (ch_emp_rank[g]),
            .lru_idx_in     (ch_lru_idx[g]),
            .lru_rank_in    (ch_lru_rank[g]),
            .lru_page_in    (ch_lru_page[g]),
            .upd            (upd),
            .upd_idx        (upd_idx),
            .upd_rank_old   (upd_rank_old),
            .upd_page       (page_reg),
            .flags_out      (ch_flags[g+1]),
            .hit_idx_out    (ch_hit_idx[g+1]),
            .hit_rank_out   (ch_hit_rank[g+1]),
            .empty_idx_out  (ch_emp_idx[g+1]),
            .empty_rank_out (ch_emp_rank[g+1]),
            .lru_idx_out    (ch_lru_idx[g+1]),
            .lru_rank_out   (ch_lru_rank[g+1]),
            .lru_page_out   (ch_lru_page[g+1])
        );
    end

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);

    // commit decision: hit frame, else first empty frame, else oldest frame
    always_comb begin
        is_clear = (cmd_reg == CMD_CLEAR);
        victim   = !res_hit_reg && !res_empty_reg;
        priority if (res_hit_reg) begin
            upd_idx      = res_hit_idx_reg;
            upd_rank_old = res_hit_rank_reg;
        end else if (res_empty_reg) begin
            upd_idx      = res_empty_idx_reg;
            upd_rank_old = res_empty_rank_reg;
        end else begin
            upd_idx      = res_lru_idx_reg;
            upd_rank_old = res_lru_rank_reg;
        end
        upd.apply = commit && !is_clear;
        upd.clear = commit && is_clear;
        upd.fill  = !res_hit_reg;

        victim_page = victim ? res_lru_page_reg : '0;

        if (is_clear) begin
            access_next = '0;
            miss_next   = '0;
        end else begin
            access_next = (access_reg == COUNT_MAX) ? access_reg : access_reg + 1'b1;
            miss_next   = (res_hit_reg || (miss_reg == COUNT_MAX)) ? miss_reg
                                                                   : miss_reg + 1'b1;
        end

        // frame index reported modulo 16
        idx_ext = (IDX_W + FRAME_INDEX_W)'(upd_idx);
        if (is_clear) begin
            m_data_next = '0;
            m_user_next = '0;
        end else begin
            m_data_next = OUT_DATA_W'({miss_next, access_next, victim_page,
                                       idx_ext[FRAME_INDEX_W-1:0]});
            m_user_next = {victim, res_hit_reg};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_axis_tuser[0] == CMD_CLEAR) ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (ch_flags[FRAMES].tok) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= s_accept && (s_axis_tuser[0] == CMD_ACCESS);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_axis_tuser[0];
            page_reg <= s_axis_tdata[PAGE_BITS-1:0];
        end
    end

    // capture the chain end once the token arrives
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SEARCH) && ch_flags[FRAMES].tok) begin
            res_hit_reg        <= ch_flags[FRAMES].hit_found;
            res_empty_reg      <= ch_flags[FRAMES].empty_found;
            res_hit_idx_reg    <= ch_hit_idx[FRAMES];
            res_hit_rank_reg   <= ch_hit_rank[FRAMES];
            res_empty_idx_reg  <= ch_emp_idx[FRAMES];
            res_empty_rank_reg <= ch_emp_rank[FRAMES];
            res_lru_idx_reg    <= ch_lru_idx[FRAMES];
            res_lru_rank_reg   <= ch_lru_rank[FRAMES];
            res_lru_page_reg   <= ch_lru_page[FRAMES];
        end
    end

    // running totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_reg <= '0;
            miss_reg   <= '0;
        end else if (commit) begin
            access_reg <= access_next;
            miss_reg   <= miss_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_FRAMES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_frames_reg <= NUM_FRAMES_RST;
        end else if (cfg_write) begin
            num_frames_reg <= pwdata[NUM_FRAMES_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NUM_FRAMES) ? APB_DATA_W'(num_frames_reg) : '0;

    // checks
    a_single_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one search token in the cell chain");

    a_idle_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (tok_vec == '0) && !launch_reg)
        else $error("search token alive while idle");

    a_hit_no_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("hit reported together with an eviction");

    a_miss_le_access: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (miss_next <= access_next))
        else $error("miss total exceeds access total");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_axis_tvalid)
        else $error("committed result not presented");

endmodule
